[src/lrht_pkg.sv]
// lrht_pkg: shared types, codes and sizing helpers for the link rectangle
// hit test block. No dependencies.
package lrht_pkg;

    // Fixed field widths
    localparam int COORD_W  = 16;
    localparam int SIZE_W   = 15;
    localparam int PAGE_W   = 16;
    localparam int ENTRY_W  = 6;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;
    localparam int OFF_W    = 24;
    localparam int LEN_W    = 16;
    localparam int CFG_W    = 7;
    // Wide enough to hold any table depth (up to 1024) for range checks
    localparam int CHK_W    = 11;

    // Default table depths
    localparam int MAX_RECTS_DEF   = 64;
    localparam int MAX_TARGETS_DEF = 64;

    // Item function codes (input tuser)
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RECT  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TGT   = 2'd2;

    // Result status codes (output tuser)
    localparam logic [STATUS_W-1:0] ST_FOUND = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_WRITE = 2'd2;

    // Input tdata, last field in the lowest bits
    typedef struct packed {
        logic [5:0]          pad;
        logic [LEN_W-1:0]    href_length_in;
        logic [OFF_W-1:0]    href_offset_in;
        logic [ENTRY_W-1:0]  target_index;
        logic [SIZE_W-1:0]   height;
        logic [SIZE_W-1:0]   width;
        logic [COORD_W-1:0]  y;
        logic [COORD_W-1:0]  x;
        logic [PAGE_W-1:0]   page;
        logic [ENTRY_W-1:0]  entry_index;
    } t_in_data;

    // Output tdata, last field in the lowest bits
    typedef struct packed {
        logic [LEN_W-1:0] href_length;
        logic [OFF_W-1:0] href_offset;
    } t_out_data;

    // One rectangle table row
    typedef struct packed {
        logic [PAGE_W-1:0]  page;
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [SIZE_W-1:0]  width;
        logic [SIZE_W-1:0]  height;
        logic [ENTRY_W-1:0] target;
    } t_rect;

    // One target table row
    typedef struct packed {
        logic [OFF_W-1:0] offset;
        logic [LEN_W-1:0] length;
    } t_tgt;

    // Controller -> datapath commands
    typedef struct packed {
        logic                capture;   // latch the input transfer
        logic                rect_we;   // write rectangle row at item slot
        logic                tgt_we;    // write target row at item slot
        logic                tgt_re;    // hit seen: latch target range check
        logic                res_load;  // load result with res_code
        logic [STATUS_W-1:0] res_code;
        logic                out_load;  // move result into output register
    } t_dp_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              rect_slot_ok;
        logic              tgt_slot_ok;
        logic              hit;         // rectangle read last cycle holds point
        logic              out_free;
    } t_dp_sts;

    function automatic int f_addr_w(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    function automatic int f_cnt_w(input int depth);
        return $clog2(depth + 1);
    endfunction

endpackage

[src/lrht_ram.sv]
// lrht_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module lrht_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/lrht_ctrl.sv]
// lrht_ctrl: sequencer for the hit test; owns the rect_count register and
// the scan counter. Depends on lrht_pkg.
module lrht_ctrl
    import lrht_pkg::*;
#(
    parameter int MAX_RECTS = MAX_RECTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_cfg_wr_en,
    input  logic [CFG_W-1:0]               i_cfg_wr_data,
    input  t_dp_sts                        i_sts,
    output t_dp_cmd                        o_cmd,
    output logic [f_addr_w(MAX_RECTS)-1:0] o_scan_idx
);

    localparam int RAW = f_addr_w(MAX_RECTS);
    localparam int CW  = f_cnt_w(MAX_RECTS);
    localparam int NW  = (CW > CFG_W) ? CW : CFG_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_TGT    = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [CW-1:0]    r_idx, n_idx;
    logic             r_pend, n_pend;
    logic [CFG_W-1:0] r_rect_count;

    logic [NW-1:0] count_x;
    logic [NW-1:0] lim_x;
    logic [CW-1:0] scan_lim;

    // clamp the scan length to the table depth
    assign count_x  = NW'(r_rect_count);
    assign lim_x    = (count_x > NW'(MAX_RECTS)) ? NW'(MAX_RECTS) : count_x;
    assign scan_lim = lim_x[CW-1:0];

    assign o_scan_idx = r_idx[RAW-1:0];
    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rect_count <= '0;
        end else if (i_cfg_wr_en) begin
            r_rect_count <= i_cfg_wr_data;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_pend  = r_pend;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.func)
                    FUNC_RECT: begin
                        o_cmd.rect_we  = i_sts.rect_slot_ok;
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_code = i_sts.rect_slot_ok ? ST_WRITE : ST_MISS;
                        n_state        = S_EMIT;
                    end
                    FUNC_TGT: begin
                        o_cmd.tgt_we   = i_sts.tgt_slot_ok;
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_code = i_sts.tgt_slot_ok ? ST_WRITE : ST_MISS;
                        n_state        = S_EMIT;
                    end
                    FUNC_QUERY: begin
                        if (scan_lim == '0) begin
                            o_cmd.res_load = 1'b1;
                            o_cmd.res_code = ST_MISS;
                            n_state        = S_EMIT;
                        end else begin
                            n_idx   = '0;
                            n_pend  = 1'b0;
                            n_state = S_SCAN;
                        end
                    end
                    default: begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_code = ST_MISS;
                        n_state        = S_EMIT;
                    end
                endcase
            end
            S_SCAN: begin
                // row r_idx is being read while row r_idx-1 is compared
                if (r_pend && i_sts.hit) begin
                    o_cmd.tgt_re = 1'b1;
                    n_state      = S_TGT;
                end else if (r_idx == scan_lim) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_code = ST_MISS;
                    n_state        = S_EMIT;
                end else begin
                    n_idx  = r_idx + 1'b1;
                    n_pend = 1'b1;
                end
            end
            S_TGT: begin
                o_cmd.res_load = 1'b1;
                o_cmd.res_code = ST_FOUND;
                n_state        = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
        end
    end

endmodule

[src/lrht_dp.sv]
// lrht_dp: item registers, rectangle and target tables, point compare,
// result and output registers. Depends on lrht_pkg and lrht_ram.
module lrht_dp
    import lrht_pkg::*;
#(
    parameter int MAX_RECTS   = MAX_RECTS_DEF,
    parameter int MAX_TARGETS = MAX_TARGETS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_dp_cmd                        i_cmd,
    output t_dp_sts                        o_sts,
    input  logic [f_addr_w(MAX_RECTS)-1:0] i_scan_idx,
    input  logic [FUNC_W-1:0]              i_func,
    input  t_in_data                       i_item,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [STATUS_W-1:0]            o_out_status,
    output t_out_data                      o_out_data
);

    localparam int RAW = f_addr_w(MAX_RECTS);
    localparam int TAW = f_addr_w(MAX_TARGETS);

    // captured item
    logic [FUNC_W-1:0] r_func;
    t_in_data          r_item;

    logic [CHK_W-1:0] slot_x;
    logic [CHK_W-1:0] tgt_x;

    t_rect wr_rect;
    t_tgt  wr_tgt;
    logic [$bits(t_rect)-1:0] rect_q;
    logic [$bits(t_tgt)-1:0]  tgt_q;
    t_rect rq;
    t_tgt  tq;

    logic signed [COORD_W:0] px_x, py_x;
    logic signed [COORD_W:0] left_x, top_x, right_x, bottom_x;
    logic                    in_x, in_y, hit;

    logic                r_tgt_ok;
    logic [STATUS_W-1:0] r_res_status;
    t_out_data           r_res_data;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    t_out_data           r_out_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_func;
            r_item <= i_item;
        end
    end

    assign slot_x = CHK_W'(r_item.entry_index);

    assign wr_rect.page   = r_item.page;
    assign wr_rect.left   = r_item.x;
    assign wr_rect.top    = r_item.y;
    assign wr_rect.width  = r_item.width;
    assign wr_rect.height = r_item.height;
    assign wr_rect.target = r_item.target_index;

    assign wr_tgt.offset = r_item.href_offset_in;
    assign wr_tgt.length = r_item.href_length_in;

    lrht_ram #(
        .WIDTH  ($bits(t_rect)),
        .DEPTH  (MAX_RECTS),
        .ADDR_W (RAW)
    ) u_rect_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.rect_we),
        .i_waddr (slot_x[RAW-1:0]),
        .i_wdata (wr_rect),
        .i_raddr (i_scan_idx),
        .o_rdata (rect_q)
    );

    assign rq    = t_rect'(rect_q);
    assign tgt_x = CHK_W'(rq.target);

    // target row follows the rectangle row on the read port
    lrht_ram #(
        .WIDTH  ($bits(t_tgt)),
        .DEPTH  (MAX_TARGETS),
        .ADDR_W (TAW)
    ) u_tgt_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.tgt_we),
        .i_waddr (slot_x[TAW-1:0]),
        .i_wdata (wr_tgt),
        .i_raddr (tgt_x[TAW-1:0]),
        .o_rdata (tgt_q)
    );

    assign tq = t_tgt'(tgt_q);

    // half-open box test, edges one bit wider than coordinates
    assign px_x     = $signed({r_item.x[COORD_W-1], r_item.x});
    assign py_x     = $signed({r_item.y[COORD_W-1], r_item.y});
    assign left_x   = $signed({rq.left[COORD_W-1], rq.left});
    assign top_x    = $signed({rq.top[COORD_W-1], rq.top});
    assign right_x  = left_x + $signed((COORD_W+1)'(rq.width));
    assign bottom_x = top_x + $signed((COORD_W+1)'(rq.height));
    assign in_x     = (px_x >= left_x) && (px_x < right_x);
    assign in_y     = (py_x >= top_x) && (py_x < bottom_x);
    assign hit      = (rq.page == r_item.page) && in_x && in_y;

    always_ff @(posedge i_clk) begin
        if (i_cmd.tgt_re) begin
            r_tgt_ok <= (tgt_x < CHK_W'(MAX_TARGETS));
        end
        if (i_cmd.res_load) begin
            r_res_status <= i_cmd.res_code;
            if ((i_cmd.res_code == ST_FOUND) && r_tgt_ok) begin
                r_res_data.href_offset <= tq.offset;
                r_res_data.href_length <= tq.length;
            end else begin
                r_res_data <= '0;
            end
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_data   <= r_res_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.func         = r_func;
    assign o_sts.rect_slot_ok = (slot_x < CHK_W'(MAX_RECTS));
    assign o_sts.tgt_slot_ok  = (slot_x < CHK_W'(MAX_TARGETS));
    assign o_sts.hit          = hit;
    assign o_sts.out_free     = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_data   = r_out_data;

endmodule

[src/link_rectangle_hit_test.sv]
// link_rectangle_hit_test: top level; joins the controller and the datapath.
// Depends on lrht_pkg, lrht_ctrl, lrht_dp (and lrht_ram below it).
//
//  Port group  Dir  Payload                                     Transfer when
//  s_axis_*    in   tuser: func; tdata: write fields / query    tvalid & tready
//  m_axis_*    out  tuser: status; tdata: href offset, length   tvalid & tready
//  i_cfg_*     in   rect_count                                  i_cfg_wr_en
//
// Steps, from the input transfer to the load of the output register: decode;
// a write, an unknown func or a query with nothing to scan then goes to emit.
// A query scans one rectangle row per cycle on the table's single read port,
// the compare in the cycle after the read; a miss scans min(rect_count,
// MAX_RECTS) rows, a hit on row k (from 0) stops there and adds a target step
// for the target table read. The input is ready again once that load is done.
// Reset: synchronous, active low; clears control state and rect_count. Table
// contents are not cleared and hold nothing meaningful until written.
// Stalls: one item is worked on at a time; a finished result sits in the
// output register while the next item is taken in, and the sequencer waits in
// its emit step only if that register is full and m_axis_tready is low.
module link_rectangle_hit_test
    import lrht_pkg::*;
#(
    parameter int MAX_RECTS   = MAX_RECTS_DEF,
    parameter int MAX_TARGETS = MAX_TARGETS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input item stream
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // entry_index, page, x, y, width, height, target_index,
    // href_offset_in, href_length_in, zero pad (lowest bit first)
    input  logic [135:0]        s_axis_tdata,
    // func
    input  logic [FUNC_W-1:0]   s_axis_tuser,
    // result stream
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // href_offset, href_length (lowest bit first)
    output logic [39:0]         m_axis_tdata,
    // status
    output logic [STATUS_W-1:0] m_axis_tuser,
    // rect_count register
    input  logic                i_cfg_wr_en,
    input  logic [CFG_W-1:0]    i_cfg_wr_data
);

    t_dp_cmd   cmd;
    t_dp_sts   sts;
    t_out_data out_data;
    logic [f_addr_w(MAX_RECTS)-1:0] scan_idx;

    // Sequencer: decode, scan count, handshake on the input side
    lrht_ctrl #(
        .MAX_RECTS (MAX_RECTS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_sts         (sts),
        .o_cmd         (cmd),
        .o_scan_idx    (scan_idx)
    );

    // Tables, box compare, result and output registers
    lrht_dp #(
        .MAX_RECTS   (MAX_RECTS),
        .MAX_TARGETS (MAX_TARGETS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_scan_idx   (scan_idx),
        .i_func       (s_axis_tuser),
        .i_item       (t_in_data'(s_axis_tdata)),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_status (m_axis_tuser),
        .o_out_data   (out_data)
    );

    assign m_axis_tdata = out_data;

endmodule

[test/tb_link_rectangle_hit_test.sv]
// tb_link_rectangle_hit_test: self-checking bench for the link rectangle hit test block.
// Depends on lrht_pkg and link_rectangle_hit_test; a directed table, then random phases
// per rect_count setting, every result checked against a shadow of both tables.
`timescale 1ns / 1ps

module tb_link_rectangle_hit_test;
    import lrht_pkg::*;

    localparam int TOTAL_ITEMS  = 750;
    localparam int DRAIN_CYCLES = 8;
    localparam int TAIL_CYCLES  = 80;      // longer than a full 64-row scan
    localparam int WATCHDOG_NS  = 6_000_000;
    localparam int COORD_MAX    = 32767;
    localparam int COORD_MIN    = -32768;
    localparam int IDLE_PCT     = 29;

    // func code the block must treat as a no-op miss
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef enum logic {ROW_ITEM, ROW_COUNT} t_row_kind;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OFF_W-1:0]    offset;
        logic [LEN_W-1:0]    length;
    } t_link_ans;

    // Directed row: either a rect_count write or one item. Typed rows carry their
    // status here; their href fields are always zero.
    typedef struct packed {
        t_row_kind           kind;
        logic [CFG_W-1:0]    count;
        logic [FUNC_W-1:0]   fn;
        logic [ENTRY_W-1:0]  entry;
        logic [PAGE_W-1:0]   page;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [SIZE_W-1:0]   w;
        logic [SIZE_W-1:0]   h;
        logic [ENTRY_W-1:0]  tgt;
        logic [OFF_W-1:0]    off;
        logic [LEN_W-1:0]    len;
        logic                typed;
        logic [STATUS_W-1:0] st;
    } t_dir_row;

    localparam int DIR_ROWS = 22;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [135:0]        s_axis_tdata  = '0;
    logic [FUNC_W-1:0]   s_axis_tuser  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [39:0]         m_axis_tdata;
    logic [STATUS_W-1:0] m_axis_tuser;
    logic                i_cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]    i_cfg_wr_data = '0;

    // shadow of the block's tables and register
    t_rect            rect_tab     [MAX_RECTS_DEF];
    t_tgt             tgt_tab      [MAX_TARGETS_DEF];
    bit               rect_written [MAX_RECTS_DEF];
    bit               tgt_written  [MAX_TARGETS_DEF];
    logic [CFG_W-1:0] count_shadow = '0;

    t_link_ans href_answers [$];
    t_link_ans head;
    t_out_data got;

    bit steady     = 1'b0;   // no idling on either side while set
    int items_sent = 0;
    int fail_cnt   = 0;
    int n_found    = 0;
    int n_miss     = 0;
    int n_write    = 0;
    int n_settings = 0;

    assign got = m_axis_tdata;

    t_dir_row dir_tab [DIR_ROWS] = '{
        // reset state: nothing scanned
        '{ROW_ITEM, 0, FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, ST_MISS},
        // unknown func with every field at its top value
        '{ROW_ITEM, 0, FUNC_UNUSED, 'h3F, 'hFFFF, 'hFFFF, 'hFFFF, 'h7FFF, 'h7FFF, 'h3F,
          'hFFFFFF, 'hFFFF, 1, ST_MISS},
        '{ROW_ITEM, 0, FUNC_TGT, 0, 0, 0, 0, 0, 0, 0, 'hFFFFFF, 'hFFFF, 1, ST_WRITE},
        '{ROW_ITEM, 0, FUNC_TGT, 63, 0, 0, 0, 0, 0, 0, 0, 0, 1, ST_WRITE},
        '{ROW_ITEM, 0, FUNC_TGT, 21, 0, 0, 0, 0, 0, 0, 'h123456, 'h0BCD, 1, ST_WRITE},
        // most negative corner, largest size
        '{ROW_ITEM, 0, FUNC_RECT, 0, 'h0000, 'h8000, 'h8000, 'h7FFF, 'h7FFF, 63, 0, 0,
          1, ST_WRITE},
        // most positive corner: right/bottom edges need the extra bit
        '{ROW_ITEM, 0, FUNC_RECT, 1, 'hFFFF, 'h7FFF, 'h7FFF, 'h7FFF, 'h7FFF, 0, 0, 0,
          1, ST_WRITE},
        // zero width
        '{ROW_ITEM, 0, FUNC_RECT, 2, 'h0005, 'h000A, 'h000A, 'h0000, 'h0005, 0, 0, 0,
          1, ST_WRITE},
        '{ROW_ITEM, 0, FUNC_RECT, 3, 'h0005, 'hFFF6, 'hFFF6, 'h0014, 'h0014, 21, 0, 0,
          1, ST_WRITE},
        // zero height in the last slot
        '{ROW_ITEM, 0, FUNC_RECT, 63, 'h0005, 'h0000, 'h0000, 'h0001, 'h0000, 0, 0, 0,
          1, ST_WRITE},
        '{ROW_COUNT, 4, FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, ST_MISS},
        '{ROW_ITEM, 0, FUNC_QUERY, 0, 'h0000, 'h8000, 'h8000, 0, 0, 0, 0, 0, 0, ST_MISS},
        '{ROW_ITEM, 0, FUNC_QUERY, 0, 'h0000, 'hFFFF, 'hFFFF, 0, 0, 0, 0, 0, 0, ST_MISS},
        '{ROW_ITEM, 0, FUNC_QUERY, 0, 'h0000, 'hFFFE, 'hFFFE, 0, 0, 0, 0, 0, 0, ST_MISS},
        '{ROW_ITEM, 0, FUNC_QUERY, 0, 'hFFFF, 'h7FFF, 'h7FFF, 0, 0, 0, 0, 0, 0, ST_MISS},
        '{ROW_ITEM, 0, FUNC_QUERY, 0, 'h0005, 'h0009, 'h0009, 0, 0, 0, 0, 0, 0, ST_MISS},
        // on the right edge of slot 3 and inside the empty slot 2: half-open miss
        '{ROW_ITEM, 0, FUNC_QUERY, 0, 'h0005, 'h000A, 'h000A, 0, 0, 0, 0, 0, 1, ST_MISS},
        '{ROW_ITEM, 0, FUNC_QUERY, 0, 'h0005, 'hFFF6, 'hFFF6, 0, 0, 0, 0, 0, 0, ST_MISS},
        // no rectangle on this page
        '{ROW_ITEM, 0, FUNC_QUERY, 0, 'h0006, 'h0000, 'h0000, 0, 0, 0, 0, 0, 1, ST_MISS},
        '{ROW_ITEM, 0, FUNC_QUERY, 0, 'hFFFF, 'h7FFE, 'h7FFF, 0, 0, 0, 0, 0, 0, ST_MISS},
        '{ROW_COUNT, 0, FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, ST_MISS},
        '{ROW_ITEM, 0, FUNC_QUERY, 0, 'h0000, 'h8000, 'h8000, 0, 0, 0, 0, 0, 1, ST_MISS}
    };

    link_rectangle_hit_test DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #6 i_clk = ~i_clk;

    // Applies one accepted item to the shadow tables and returns its answer.
    function automatic t_link_ans resolve_item(input logic [FUNC_W-1:0] fn,
                                               input t_in_data d);
        t_link_ans a;
        int        scan, px, py, l, t, w, h, i;
        bit        hit;
        a = '{ST_MISS, '0, '0};
        if (fn == FUNC_RECT) begin
            rect_tab[d.entry_index] = '{d.page, d.x, d.y, d.width, d.height, d.target_index};
            rect_written[d.entry_index] = 1'b1;
            a.status = ST_WRITE;
        end else if (fn == FUNC_TGT) begin
            tgt_tab[d.entry_index] = '{d.href_offset_in, d.href_length_in};
            tgt_written[d.entry_index] = 1'b1;
            a.status = ST_WRITE;
        end else if (fn == FUNC_QUERY) begin
            scan = (count_shadow > MAX_RECTS_DEF) ? MAX_RECTS_DEF : count_shadow;
            px   = $signed(d.x);
            py   = $signed(d.y);
            hit  = 1'b0;
            for (i = 0; i < scan && !hit; i++) begin
                l = $signed(rect_tab[i].left);
                t = $signed(rect_tab[i].top);
                w = rect_tab[i].width;
                h = rect_tab[i].height;
                // first match wins; edges are exclusive on the right and bottom
                if (rect_tab[i].page == d.page && px >= l && px < l + w &&
                    py >= t && py < t + h) begin
                    hit = 1'b1;
                    a   = '{ST_FOUND, tgt_tab[rect_tab[i].target].offset,
                            tgt_tab[rect_tab[i].target].length};
                end
            end
        end
        return a;
    endfunction

    function automatic t_in_data rand_fields();
        t_in_data d;
        d     = {$urandom(), $urandom(), $urandom(), $urandom(), 8'($urandom())};
        d.pad = '0;
        return d;
    endfunction

    // only targets already loaded, so a hit never reads an empty row
    function automatic logic [ENTRY_W-1:0] pick_target();
        logic [ENTRY_W-1:0] t;
        t = ENTRY_W'($urandom());
        while (!tgt_written[t]) t = t + 1'b1;
        return t;
    endfunction

    // A coordinate inside a span most of the time, on or just past its edges otherwise.
    function automatic logic [COORD_W-1:0] coord_in(input logic [COORD_W-1:0] lo,
                                                   input logic [SIZE_W-1:0] size);
        int l, s, v;
        l = $signed(lo);
        s = size;
        case ($urandom_range(0, 9))
            0: v = l;
            1: v = l + s - 1;
            2: v = l + s;
            3: v = l - 1;
            default: v = (s == 0) ? l : l + int'($urandom_range(0, s - 1));
        endcase
        if (v > COORD_MAX) v = COORD_MAX;
        if (v < COORD_MIN) v = COORD_MIN;
        return 16'(v);
    endfunction

    function automatic t_in_data rand_rect(input logic [ENTRY_W-1:0] slot);
        t_in_data d;
        int       sel;
        d              = rand_fields();
        d.entry_index  = slot;
        d.target_index = pick_target();
        sel            = $urandom_range(0, 9);
        if (sel < 7) begin
            // small, crowded area on a few pages so rectangles overlap
            d.page   = PAGE_W'($urandom_range(0, 3));
            d.x      = 16'($urandom_range(0, 1023) - 512);
            d.y      = 16'($urandom_range(0, 1023) - 512);
            d.width  = SIZE_W'($urandom_range(1, 300));
            d.height = SIZE_W'($urandom_range(1, 300));
            if (sel == 6) begin
                if ($urandom_range(0, 1)) d.width = '0;
                else d.height = '0;
            end
        end else if (sel == 7) begin
            // against the positive limit
            d.page = PAGE_W'($urandom_range(0, 3));
            d.x    = 16'(COORD_MAX - int'($urandom_range(0, 40)));
            d.y    = 16'(COORD_MAX - int'($urandom_range(0, 40)));
        end
        return d;
    endfunction

    function automatic t_in_data aim_query(input int scan);
        t_in_data d;
        t_rect    r;
        d = rand_fields();
        if (scan > 0) begin
            r      = rect_tab[$urandom_range(0, scan - 1)];
            d.page = r.page;
            d.x    = coord_in(r.left, r.width);
            d.y    = coord_in(r.top, r.height);
        end
        return d;
    endfunction

    task automatic send_item(input logic [FUNC_W-1:0] fn, input t_in_data d,
                             input bit typed, input logic [STATUS_W-1:0] st);
        t_link_ans a;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= fn;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        a = resolve_item(fn, d);
        if (typed) a = '{st, '0, '0};
        href_answers.push_back(a);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (href_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // register write only with the block idle
    task automatic load_rect_count(input logic [CFG_W-1:0] n);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= n;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        count_shadow = n;
        n_settings++;
    endtask

    // result side: check each transfer, then pick next tready
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (href_answers.size() == 0) begin
                fail_cnt++;
                $display("%0t: unexpected result, expected none, actual status %0d %h %h",
                         $time, m_axis_tuser, got.href_offset, got.href_length);
            end else begin
                head = href_answers.pop_front();
                if (m_axis_tuser !== head.status) begin
                    fail_cnt++;
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, head.status, m_axis_tuser);
                end
                if (got.href_offset !== head.offset) begin
                    fail_cnt++;
                    $display("%0t: href_offset mismatch, expected %h, actual %h",
                             $time, head.offset, got.href_offset);
                end
                if (got.href_length !== head.length) begin
                    fail_cnt++;
                    $display("%0t: href_length mismatch, expected %h, actual %h",
                             $time, head.length, got.href_length);
                end
                case (head.status)
                    ST_FOUND: n_found++;
                    ST_WRITE: n_write++;
                    default:  n_miss++;
                endcase
            end
        end
        m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    initial begin
        #(WATCHDOG_NS);
        $display("Timeout at %0t with %0d results outstanding", $time, href_answers.size());
        $display("Verification failed");
        $finish;
    end

    initial begin
        int               k, phase, scan, n_items, sel, s;
        t_in_data         d;
        logic [CFG_W-1:0] cnt;
        t_dir_row         row;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (k = 0; k < DIR_ROWS; k++) begin
            row = dir_tab[k];
            if (row.kind == ROW_COUNT) begin
                load_rect_count(row.count);
            end else begin
                d                = '0;
                d.entry_index    = row.entry;
                d.page           = row.page;
                d.x              = row.x;
                d.y              = row.y;
                d.width          = row.w;
                d.height         = row.h;
                d.target_index   = row.tgt;
                d.href_offset_in = row.off;
                d.href_length_in = row.len;
                send_item(row.fn, d, row.typed, row.st);
            end
        end

        // random phases, one rect_count setting each; extremes come first
        phase = 0;
        while (items_sent < TOTAL_ITEMS) begin
            case (phase)
                0: cnt = CFG_W'(1);
                1: cnt = CFG_W'(MAX_RECTS_DEF);
                2: cnt = '1;
                3: cnt = '0;
                4: cnt = CFG_W'(MAX_RECTS_DEF + 1);
                default: begin
                    if ($urandom_range(0, 3) == 0) cnt = CFG_W'($urandom_range(0, 127));
                    else cnt = CFG_W'($urandom_range(1, MAX_RECTS_DEF));
                end
            endcase
            scan = (cnt > MAX_RECTS_DEF) ? MAX_RECTS_DEF : cnt;
            // every scanned row must hold something before the count covers it
            for (s = 0; s < scan; s++) begin
                if (!rect_written[s]) send_item(FUNC_RECT, rand_rect(6'(s)), 1'b0, ST_WRITE);
            end
            load_rect_count(cnt);
            n_items = $urandom_range(30, 80);
            if (n_items > TOTAL_ITEMS - items_sent) n_items = TOTAL_ITEMS - items_sent;
            if (n_items < 0) n_items = 0;
            repeat (n_items) begin
                steady = (items_sent >= 300 && items_sent < 420);
                sel    = $urandom_range(0, 99);
                if (sel < 45) begin
                    send_item(FUNC_QUERY, aim_query(scan), 1'b0, ST_MISS);
                end else if (sel < 55) begin
                    d = rand_fields();
                    if (sel < 50) d.page = PAGE_W'($urandom_range(0, 3));
                    send_item(FUNC_QUERY, d, 1'b0, ST_MISS);
                end else if (sel < 75) begin
                    send_item(FUNC_RECT, rand_rect(6'($urandom())), 1'b0, ST_WRITE);
                end else if (sel < 93) begin
                    send_item(FUNC_TGT, rand_fields(), 1'b0, ST_WRITE);
                end else begin
                    send_item(FUNC_UNUSED, rand_fields(), 1'b0, ST_MISS);
                end
            end
            steady = 1'b0;
            phase++;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d transfers: %0d hits, %0d misses, %0d write acks",
                 items_sent, n_found, n_miss, n_write);
        $display("over %0d rect_count settings, including 0, 1, 64, 65 and 127", n_settings);
        if (fail_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
